// ----- src/sfr_pkg.sv -----
// package for the framed receiver: payload structs and fixed constants
// no dependencies; imported by sync_framed_receiver_crc_hamming_unit
package sfr_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_CHAR      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLYNOMIAL = 2'd1;

    // register reset values
    localparam logic [6:0]  SYNC_CHAR_RST = 7'd22;
    localparam logic [15:0] CRC_POLY_RST  = 16'h8005;

    // substitute for a character that fails odd parity ('#')
    localparam logic [6:0] BAD_CHAR = 7'd35;

    // frame modes
    localparam logic [6:0] MODE_PLAIN   = 7'd0;
    localparam logic [6:0] MODE_CRC     = 7'd1;
    localparam logic [6:0] MODE_HAMMING = 7'd2;

    // frame status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0] STATUS_BAD_MODE = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [3:0] check_bits;
    } sfr_in_t;

    typedef struct packed {
        logic [6:0]  character;
        logic        char_valid;
        logic        parity_fail;
        logic        corrected;
        logic [2:0]  corrected_bit;
        logic [6:0]  byte_index;
        logic        frame_end;
        logic [1:0]  frame_status;
        logic [15:0] frame_number;
    } sfr_out_t;

endpackage

// ----- src/sync_framed_receiver_crc_hamming_unit.sv -----
// framed receiver top level: sync hunt, header decode, crc-16 and hamming(12,8)
// depends on sfr_pkg for payload structs, register indexes and constants

// Synchronous framed receiver. Each input transaction carries one received
// byte (bit 7 is odd parity) plus four Hamming check bits. The receiver hunts
// for two sync characters, reads a mode and a length character, then passes
// each payload character on as one result transaction; the last result of a
// frame has frame_end set and carries the frame status. Header characters give
// no result, except a zero length, which gives one status-only result. Mode 1
// checks a CRC-16 over the raw payload bytes (the last two carry the CRC, so
// they come out with char_valid low); mode 2 corrects a single data bit using
// inverted check bits before the parity check; modes above 2 give only a
// status-only result on the last payload byte. Throughput is one transaction
// per clock while results are taken: an input register feeds one pass of
// parity, syndrome and bytewise CRC logic into the result register, which
// drives m_valid. s_ready drops only while the input register holds a
// transaction and the result register is full and not being taken.
// Configuration (sync_char at index 0, crc_polynomial at index 1) is always
// accepted; other indexes are ignored. Write it only while the block is idle.
module sync_framed_receiver_crc_hamming_unit
    import sfr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  sfr_in_t                s_data,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output sfr_out_t               m_data,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // receiver phase
    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_MODE,
        PH_LEN,
        PH_DATA
    } phase_t;

    // configuration registers
    logic [6:0]  sync_char_reg;
    logic [15:0] crc_poly_reg;

    // input register
    logic        in_valid_reg;
    sfr_in_t     in_reg;

    // frame state
    phase_t      phase_reg,        phase_next;
    logic [6:0]  frame_mode_reg,   frame_mode_next;
    logic [6:0]  frame_length_reg, frame_length_next;
    logic [6:0]  byte_count_reg,   byte_count_next;
    logic [15:0] crc_reg,          crc_next;
    logic [15:0] frame_counter_reg, frame_counter_next;

    // result register
    logic        out_valid_reg;
    sfr_out_t    out_reg;

    // datapath signals
    logic        advance;
    logic        has_res;
    sfr_out_t    res;
    logic        hdr_fail;
    logic [6:0]  hdr_char;
    logic [3:0]  syndrome;
    logic        syn_hit;
    logic [2:0]  syn_bit;
    logic        fix_en;
    logic [7:0]  fixed_byte;
    logic        dat_fail;
    logic [6:0]  dat_char;
    logic [15:0] crc_step;
    logic        is_last;
    logic        is_data;

    // one byte of the crc, msb first, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] rem,
                                             input logic [7:0]  b,
                                             input logic [15:0] poly);
        logic [15:0] r;
        r = rem ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ poly;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    // pipeline control: the input register moves on when the result
    // register is empty or is being emptied in this cycle
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    // header characters: odd parity, failures become '#'
    assign hdr_fail = ~^in_reg.rx_byte;
    assign hdr_char = hdr_fail ? BAD_CHAR : in_reg.rx_byte[6:0];

    // hamming(12,8) syndrome, check bits sent inverted
    assign syndrome[3] = ~(in_reg.rx_byte[3] ^ in_reg.rx_byte[2] ^ in_reg.rx_byte[1]
                         ^ in_reg.rx_byte[0]) ^ in_reg.check_bits[3];
    assign syndrome[2] = ~(in_reg.rx_byte[6] ^ in_reg.rx_byte[5] ^ in_reg.rx_byte[4]
                         ^ in_reg.rx_byte[0]) ^ in_reg.check_bits[2];
    assign syndrome[1] = ~(in_reg.rx_byte[7] ^ in_reg.rx_byte[5] ^ in_reg.rx_byte[4]
                         ^ in_reg.rx_byte[2] ^ in_reg.rx_byte[1]) ^ in_reg.check_bits[1];
    assign syndrome[0] = ~(in_reg.rx_byte[7] ^ in_reg.rx_byte[6] ^ in_reg.rx_byte[4]
                         ^ in_reg.rx_byte[3] ^ in_reg.rx_byte[1]) ^ in_reg.check_bits[0];

    // syndrome to data bit; check-bit positions and zero leave the byte alone
    always_comb begin
        syn_hit = 1'b1;
        syn_bit = 3'd0;
        unique case (syndrome)
            4'd12:   syn_bit = 3'd0;
            4'd11:   syn_bit = 3'd1;
            4'd10:   syn_bit = 3'd2;
            4'd9:    syn_bit = 3'd3;
            4'd7:    syn_bit = 3'd4;
            4'd6:    syn_bit = 3'd5;
            4'd5:    syn_bit = 3'd6;
            4'd3:    syn_bit = 3'd7;
            default: syn_hit = 1'b0;
        endcase
    end

    assign fix_en     = syn_hit && (frame_mode_reg == MODE_HAMMING);
    assign fixed_byte = fix_en ? (in_reg.rx_byte ^ (8'd1 << syn_bit)) : in_reg.rx_byte;
    assign dat_fail   = ~^fixed_byte;
    assign dat_char   = dat_fail ? BAD_CHAR : fixed_byte[6:0];

    // crc runs over the raw received byte
    assign crc_step = crc_byte(crc_reg, in_reg.rx_byte, crc_poly_reg);

    // last byte and data/crc split by payload position
    assign is_last = ({1'b0, byte_count_reg} + 8'd1) >= {1'b0, frame_length_reg};
    assign is_data = (frame_mode_reg != MODE_CRC)
                   || (({1'b0, byte_count_reg} + 8'd2) < {1'b0, frame_length_reg});

    // next state and result for the transaction in the input register
    always_comb begin
        phase_next         = phase_reg;
        frame_mode_next    = frame_mode_reg;
        frame_length_next  = frame_length_reg;
        byte_count_next    = byte_count_reg;
        crc_next           = crc_reg;
        frame_counter_next = frame_counter_reg;
        has_res            = 1'b0;
        res                = '0;
        res.frame_number   = frame_counter_reg;

        unique case (phase_reg)
            PH_SYNC1: begin
                if (hdr_char == sync_char_reg) begin
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                // a mismatch is not retried as a first sync
                phase_next = (hdr_char == sync_char_reg) ? PH_MODE : PH_SYNC1;
            end
            PH_MODE: begin
                frame_mode_next = hdr_char;
                phase_next      = PH_LEN;
            end
            PH_LEN: begin
                frame_length_next = hdr_char;
                byte_count_next   = '0;
                crc_next          = '0;
                if (hdr_char == 7'd0) begin
                    // empty frame: status-only result at once
                    has_res            = 1'b1;
                    res.frame_end      = 1'b1;
                    res.frame_status   = (frame_mode_reg <= MODE_HAMMING) ? STATUS_OK
                                                                          : STATUS_BAD_MODE;
                    frame_counter_next = frame_counter_reg + 16'd1;
                    phase_next         = PH_SYNC1;
                end else begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA: begin
                byte_count_next = byte_count_reg + 7'd1;
                crc_next        = crc_step;
                res.byte_index  = byte_count_reg;
                if (frame_mode_reg > MODE_HAMMING) begin
                    has_res          = is_last;
                    res.frame_end    = 1'b1;
                    res.frame_status = STATUS_BAD_MODE;
                end else begin
                    has_res           = 1'b1;
                    res.character     = dat_char;
                    res.char_valid    = is_data;
                    res.parity_fail   = dat_fail;
                    res.corrected     = fix_en;
                    res.corrected_bit = fix_en ? syn_bit : 3'd0;
                    res.frame_end     = is_last;
                    if (is_last && (frame_mode_reg == MODE_CRC) && (crc_step != 16'd0)) begin
                        res.frame_status = STATUS_CRC_ERR;
                    end
                end
                if (is_last) begin
                    frame_counter_next = frame_counter_reg + 16'd1;
                    phase_next         = PH_SYNC1;
                end
            end
            default: begin
                phase_next = PH_SYNC1;
            end
        endcase
    end

    // all state, configuration and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_char_reg     <= SYNC_CHAR_RST;
            crc_poly_reg      <= CRC_POLY_RST;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            phase_reg         <= PH_SYNC1;
            frame_mode_reg    <= '0;
            frame_length_reg  <= '0;
            byte_count_reg    <= '0;
            crc_reg           <= '0;
            frame_counter_reg <= 16'd1;
        end else begin
            // configuration transaction
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_SYNC_CHAR:      sync_char_reg <= cfg_data[6:0];
                    REG_CRC_POLYNOMIAL: crc_poly_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // input register
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_reg       <= s_data;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            // frame state and result register
            if (advance) begin
                phase_reg         <= phase_next;
                frame_mode_reg    <= frame_mode_next;
                frame_length_reg  <= frame_length_next;
                byte_count_reg    <= byte_count_next;
                crc_reg           <= crc_next;
                frame_counter_reg <= frame_counter_next;
                out_valid_reg     <= has_res;
                if (has_res) begin
                    out_reg <= res;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    // the frame number moves on exactly when a frame-ending result is loaded
    a_frame_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && has_res && res.frame_end)
        |=> (frame_counter_reg == $past(frame_counter_reg) + 16'd1))
        else $error("frame counter did not advance at frame end");

    // a nonzero status only ever rides on the last result of a frame
    a_status_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_reg.frame_status != STATUS_OK)) |-> out_reg.frame_end)
        else $error("frame status set on a result that is not frame end");

    // payload phase never runs with an empty frame length
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (frame_length_reg != 7'd0))
        else $error("payload phase with zero frame length");

    // the input side only stalls behind a held transaction
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");
`endif

endmodule
